// ----- sv/mis_pkg.sv -----
package mis_pkg;

    localparam int MEM_WORDS_DEF = 4096;

    localparam logic [1:0] FUNC_MEM_WRITE = 2'd0;
    localparam logic [1:0] FUNC_SET_REG   = 2'd1;
    localparam logic [1:0] FUNC_EXECUTE   = 2'd2;
    localparam logic [1:0] FUNC_MEM_READ  = 2'd3;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_NOEXEC  = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [15:0] MASK_SINGLE = 16'h7FC0;
    localparam logic [15:0] PAT_CLR     = 16'h0A00;
    localparam logic [15:0] PAT_INC     = 16'h0A80;
    localparam logic [15:0] PAT_DEC     = 16'h0AC0;
    localparam logic [15:0] MASK_DOUBLE = 16'h7000;
    localparam logic [15:0] PAT_MOV     = 16'h1000;
    localparam logic [15:0] PAT_CMP     = 16'h2000;
    localparam logic [15:0] MASK_WORD   = 16'hF000;
    localparam logic [15:0] PAT_ADD     = 16'h6000;
    localparam logic [15:0] PAT_SUB     = 16'hE000;

    localparam logic [2:0] MODE_REG     = 3'd0;
    localparam logic [2:0] MODE_DEF     = 3'd1;
    localparam logic [2:0] MODE_INC     = 3'd2;
    localparam logic [2:0] MODE_INC_DEF = 3'd3;
    localparam logic [2:0] MODE_DEC     = 3'd4;
    localparam logic [2:0] MODE_DEC_DEF = 3'd5;
    localparam logic [2:0] MODE_IDX     = 3'd6;
    localparam logic [2:0] MODE_IDX_DEF = 3'd7;

    localparam logic [2:0]  PC_IDX   = 3'd7;
    localparam logic [15:0] STEP_INC = 16'h0002;
    localparam logic [15:0] STEP_DEC = 16'hFFFE;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [2:0]  reg_index;
        logic [15:0] data;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] pc_value;
        logic [1:0]  status;
    } result_t;

    // one access to the word store, byte addressed
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [15:0] wdata;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEM_WR,
        S_SET_REG,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_FETCH,
        S_DECODE,
        S_OPND,
        S_IDX_WAIT,
        S_PTR_WAIT,
        S_ACCESS,
        S_SRC_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_CLR,
        OP_MOV,
        OP_SKIP,
        OP_BAD
    } op_t;

    function automatic op_t decode_op(logic [15:0] w);
        op_t op;
        if ((w & MASK_SINGLE) == PAT_CLR)
            op = OP_CLR;
        else if ((w & MASK_SINGLE) == PAT_INC || (w & MASK_SINGLE) == PAT_DEC)
            op = OP_SKIP;
        else if ((w & MASK_DOUBLE) == PAT_MOV)
            op = OP_MOV;
        else if ((w & MASK_DOUBLE) == PAT_CMP)
            op = OP_SKIP;
        else if ((w & MASK_WORD) == PAT_ADD || (w & MASK_WORD) == PAT_SUB)
            op = OP_SKIP;
        else
            op = OP_BAD;
        return op;
    endfunction

endpackage

// ----- sv/mis_mem.sv -----
module mis_mem #(
    parameter int MEM_WORDS = mis_pkg::MEM_WORDS_DEF
) (
    input  logic             clk,
    input  mis_pkg::mem_req_t req,
    output logic [15:0]      rdata
);
    import mis_pkg::*;

    // the user must keep the depth a power of two, which this block does not enforce; the byte address wraps onto it
    localparam int AW = $clog2(MEM_WORDS);

    logic [15:0]   mem [MEM_WORDS];
    logic [AW-1:0] idx;

    assign idx = req.addr[AW:1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[idx] <= req.wdata;
        end
        rdata <= mem[idx];
    end

endmodule

// ----- sv/minicomputer_instruction_step_core.sv -----
// Sixteen-bit minicomputer step core: eight general registers (R7 is the PC) and a
// word store of MEM_WORDS words (a power of two) reached by byte address. One transaction
// writes a word, sets a register, reads a word, or fetches and executes one instruction
// (CLR and MOV carried out, INC/DEC/CMP/ADD/SUB only skipped) with all eight addressing
// modes. Transactions are handled one at a time under a small sequencer that drives a
// single 16-bit adder, one register-file port and the single port of the word store.
// A transaction takes longer the more word-store accesses it makes, the longest being a MOV
// with two index-deferred operands; each read waits on the word store's registered read data.
// The next transaction is taken while a finished result still waits.
module minicomputer_instruction_step_core #(
    parameter int MEM_WORDS = mis_pkg::MEM_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mis_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output mis_pkg::result_t result
);
    import mis_pkg::*;

    state_t      state_reg, state_next;
    item_t       item_reg;
    logic [15:0] instr_reg;
    logic [2:0]  mode_reg;
    logic [2:0]  rn_reg;
    logic        dst_reg;
    logic        loc_is_reg_reg;
    logic [15:0] loc_reg;
    logic [15:0] val_reg;
    logic [15:0] rdata_reg;
    logic [1:0]  status_reg;
    result_t     out_reg;
    logic        out_valid_reg;
    logic [15:0] gr_reg [8];

    logic [2:0]  rf_raddr;
    logic [15:0] rf_rdata;
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic [15:0] add_b;
    logic [15:0] sum;
    mem_req_t    mem_req;
    logic [15:0] mem_rdata;
    op_t         dec_op;
    logic        fin_fire;

    mis_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .clk  (clk),
        .req  (mem_req),
        .rdata(mem_rdata)
    );

    assign rf_rdata = gr_reg[rf_raddr];
    assign sum      = rf_rdata + add_b;
    assign dec_op   = decode_op(mem_rdata);
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || !result_stall);

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.func)
                        FUNC_MEM_WRITE: state_next = S_MEM_WR;
                        FUNC_SET_REG:   state_next = S_SET_REG;
                        FUNC_EXECUTE:   state_next = S_FETCH;
                        default:        state_next = S_RD_ISSUE;
                    endcase
                end
            end
            S_MEM_WR:   state_next = S_FIN;
            S_SET_REG:  state_next = S_FIN;
            S_RD_ISSUE: state_next = S_RD_WAIT;
            S_RD_WAIT:  state_next = S_FIN;
            S_FETCH:    state_next = S_DECODE;
            S_DECODE:
            begin
                if (dec_op == OP_CLR || dec_op == OP_MOV)
                    state_next = S_OPND;
                else
                    state_next = S_FIN;
            end
            S_OPND:
            begin
                if (mode_reg inside {MODE_INC_DEF, MODE_DEC_DEF})
                    state_next = S_PTR_WAIT;
                else if (mode_reg inside {MODE_IDX, MODE_IDX_DEF})
                    state_next = S_IDX_WAIT;
                else
                    state_next = S_ACCESS;
            end
            S_IDX_WAIT:
            begin
                if (mode_reg == MODE_IDX_DEF)
                    state_next = S_PTR_WAIT;
                else
                    state_next = S_ACCESS;
            end
            S_PTR_WAIT: state_next = S_ACCESS;
            S_ACCESS:
            begin
                if (dst_reg)
                    state_next = S_FIN;
                else if (loc_is_reg_reg)
                    state_next = S_OPND;
                else
                    state_next = S_SRC_WAIT;
            end
            S_SRC_WAIT: state_next = S_OPND;
            S_FIN:
            begin
                if (fin_fire)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath controls: register-file port, adder operand, word-store access
    always_comb
    begin
        rf_raddr = rn_reg;
        add_b    = STEP_INC;
        rf_we    = 1'b0;
        rf_waddr = rn_reg;
        rf_wdata = sum;
        mem_req  = '{we: 1'b0, addr: loc_reg, wdata: val_reg};
        case (state_reg)
            S_MEM_WR:
            begin
                mem_req = '{we: 1'b1, addr: item_reg.address, wdata: item_reg.data};
            end
            S_SET_REG:
            begin
                rf_we    = 1'b1;
                rf_waddr = item_reg.reg_index;
                rf_wdata = item_reg.data;
            end
            S_RD_ISSUE:
            begin
                mem_req.addr = item_reg.address;
            end
            S_FETCH:
            begin
                rf_raddr     = PC_IDX;
                mem_req.addr = rf_rdata;
                rf_we        = 1'b1;
                rf_waddr     = PC_IDX;
            end
            S_OPND:
            begin
                case (mode_reg)
                    MODE_INC:
                    begin
                        rf_we = 1'b1;
                    end
                    MODE_INC_DEF:
                    begin
                        rf_we        = 1'b1;
                        mem_req.addr = rf_rdata;
                    end
                    MODE_DEC:
                    begin
                        add_b = STEP_DEC;
                        rf_we = 1'b1;
                    end
                    MODE_DEC_DEF:
                    begin
                        add_b        = STEP_DEC;
                        rf_we        = 1'b1;
                        mem_req.addr = sum;
                    end
                    MODE_IDX, MODE_IDX_DEF:
                    begin
                        // index word sits at the PC
                        rf_raddr     = PC_IDX;
                        mem_req.addr = rf_rdata;
                        rf_we        = 1'b1;
                        rf_waddr     = PC_IDX;
                    end
                    default:
                    begin
                        rf_we = 1'b0;
                    end
                endcase
            end
            S_IDX_WAIT:
            begin
                add_b        = mem_rdata;
                mem_req.addr = sum;
            end
            S_ACCESS:
            begin
                if (loc_is_reg_reg)
                begin
                    rf_raddr = loc_reg[2:0];
                    rf_we    = dst_reg;
                    rf_waddr = loc_reg[2:0];
                    rf_wdata = val_reg;
                end
                else
                begin
                    mem_req.we = dst_reg;
                end
            end
            S_FIN:
            begin
                rf_raddr = PC_IDX;
            end
            default:
            begin
                rf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            dst_reg       <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                gr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we)
            begin
                gr_reg[rf_waddr] <= rf_wdata;
            end
            if (fin_fire)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_DECODE:   dst_reg <= (dec_op == OP_CLR);
                S_ACCESS:   dst_reg <= 1'b1;
                S_SRC_WAIT: dst_reg <= 1'b1;
                default:    dst_reg <= dst_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_reg   <= item;
                    rdata_reg  <= '0;
                    status_reg <= STATUS_DONE;
                end
            end
            S_RD_WAIT:
            begin
                rdata_reg <= mem_rdata;
            end
            S_DECODE:
            begin
                instr_reg <= mem_rdata;
                case (dec_op)
                    OP_CLR:
                    begin
                        mode_reg <= mem_rdata[5:3];
                        rn_reg   <= mem_rdata[2:0];
                        val_reg  <= '0;
                    end
                    OP_MOV:
                    begin
                        mode_reg <= mem_rdata[11:9];
                        rn_reg   <= mem_rdata[8:6];
                    end
                    OP_SKIP: status_reg <= STATUS_NOEXEC;
                    default: status_reg <= STATUS_UNKNOWN;
                endcase
            end
            S_OPND:
            begin
                loc_is_reg_reg <= (mode_reg == MODE_REG);
                if (mode_reg == MODE_REG)
                    loc_reg <= {13'd0, rn_reg};
                else if (mode_reg == MODE_DEC)
                    loc_reg <= sum;
                else
                    loc_reg <= rf_rdata;
            end
            S_IDX_WAIT:
            begin
                loc_reg <= sum;
            end
            S_PTR_WAIT:
            begin
                loc_reg <= mem_rdata;
            end
            S_ACCESS:
            begin
                // source held in a register: value taken now, move on to the destination
                if (!dst_reg && loc_is_reg_reg)
                begin
                    val_reg  <= rf_rdata;
                    mode_reg <= instr_reg[5:3];
                    rn_reg   <= instr_reg[2:0];
                end
            end
            S_SRC_WAIT:
            begin
                val_reg  <= mem_rdata;
                mode_reg <= instr_reg[5:3];
                rn_reg   <= instr_reg[2:0];
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    out_reg <= '{read_data: rdata_reg, pc_value: rf_rdata,
                                 status: status_reg};
                end
            end
            default:
            begin
                loc_reg <= loc_reg;
            end
        endcase
    end

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result appeared without a finishing step");

    a_fetch_steps_pc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> gr_reg[PC_IDX] == $past(gr_reg[PC_IDX]) + STEP_INC)
        else $error("instruction fetch did not advance the PC by one word");

    a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_reg.read_data == '0 || item_reg.func == FUNC_MEM_READ))
        else $error("read data returned for a transaction that is not a read");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == STATUS_DONE || out_reg.status == STATUS_NOEXEC
                           || out_reg.status == STATUS_UNKNOWN))
        else $error("result status outside the defined codes");

    a_status_done_unless_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && item_reg.func != FUNC_EXECUTE |-> out_reg.status == STATUS_DONE)
        else $error("non-execute transaction reported an instruction status");

endmodule
